FILE: rtl/assert_macros.svh
// Assertion macros used by the RTL of the sorted key table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, muted while reset is asserted.
`define SKT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked check that also holds while reset is asserted.
`define SKT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: rtl/skt_pkg.sv
// Shared constants, codes and types of the sorted key table.
`timescale 1ns / 1ps
package skt_pkg;

  // Table geometry
  localparam int unsigned DEPTH     = 16;
  localparam int unsigned KEY_BITS  = 16;
  localparam int unsigned DATA_BITS = 32;

  localparam int unsigned PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned ENTRY_W = KEY_BITS + DATA_BITS;

  // Port field widths
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned KEY_W    = 16;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned STATUS_W = 2;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

  typedef logic [KEY_BITS-1:0]  key_t;
  typedef logic [DATA_BITS-1:0] data_t;

  typedef struct packed {
    key_t  key;
    data_t data;
  } entry_t;

endpackage

FILE: rtl/sorted_key_table_unit.sv
// Sorted key table: ordered key/payload store with insert, lookup and remove.
//
//  channel | signals                                      | direction
//  --------+----------------------------------------------+----------
//  request | in_valid_i/in_ready_o, command_i, key_i,     | in
//          | entry_data_i                                 |
//  result  | out_valid_o/out_ready_i, found_o,            | out
//          | found_data_o, entry_count_o, status_o        |
//
// Entries live in one RAM with one write port and one registered read port,
// and a request walks the table one entry per cycle. Insert moves each entry
// with a greater key up one slot; into an empty table it writes directly.
// Lookup scans upward to the first match; remove then moves each entry above
// the match down one slot. Refused or empty-table cases finish without a read.
// Reset clears the count and the output valid flag; RAM contents need no clear.
// A result waits in a holding register while the output is stalled; the next
// request is taken once the pending result has moved to the output register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sorted_key_table_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [skt_pkg::CMD_W-1:0]       command_i,
  input  logic [skt_pkg::KEY_W-1:0]       key_i,
  input  logic [skt_pkg::DATA_W-1:0]      entry_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            found_o,
  output logic [skt_pkg::DATA_W-1:0]      found_data_o,
  output logic [skt_pkg::COUNT_W-1:0]     entry_count_o,
  output logic [skt_pkg::STATUS_W-1:0]    status_o
);

  // Sequencer states
  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_INS      = 3'd1;
  localparam logic [2:0] S_INS_LAST = 3'd2;
  localparam logic [2:0] S_SRCH     = 3'd3;
  localparam logic [2:0] S_RM       = 3'd4;
  localparam logic [2:0] S_HOLD     = 3'd5;

  logic [2:0]                     state_q, state_d;
  logic [skt_pkg::CMD_W-1:0]      cmd_q, cmd_d;
  skt_pkg::key_t                  key_q, key_d;
  skt_pkg::data_t                 data_q, data_d;
  logic [skt_pkg::PTR_W-1:0]      ptr_q, ptr_d;
  logic [skt_pkg::CNT_W-1:0]      count_q, count_d;

  // Pending result while the output register is busy
  logic                           res_found_q, res_found_d;
  skt_pkg::data_t                 res_data_q, res_data_d;
  logic [skt_pkg::STATUS_W-1:0]   res_status_q, res_status_d;

  // Output register
  logic                           out_valid_q, out_valid_d;
  logic                           out_found_q, out_found_d;
  logic [skt_pkg::DATA_W-1:0]     out_data_q, out_data_d;
  logic [skt_pkg::COUNT_W-1:0]    out_count_q, out_count_d;
  logic [skt_pkg::STATUS_W-1:0]   out_status_q, out_status_d;

  // RAM port signals
  logic                           ram_we, ram_re;
  logic [skt_pkg::PTR_W-1:0]      ram_waddr, ram_raddr;
  skt_pkg::entry_t                ram_wdata, ram_rdata;

  // Completion of the current request
  logic                           fin_en;
  logic                           fin_found;
  skt_pkg::data_t                 fin_data;
  logic [skt_pkg::STATUS_W-1:0]   fin_status;

  skt_pkg::key_t                  in_key;
  skt_pkg::data_t                 in_data;
  logic                           out_free;
  logic                           load_out;
  logic [skt_pkg::PTR_W-1:0]      ptr_last, ptr_inc, ptr_dec;
  logic                           ptr_at_last;

  skt_ram #(
    .WIDTH (skt_pkg::ENTRY_W),
    .DEPTH (skt_pkg::DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_key      = skt_pkg::key_t'(key_i);
  assign in_data     = skt_pkg::data_t'(entry_data_i);
  assign out_free    = !out_valid_q || out_ready_i;
  assign ptr_last    = skt_pkg::PTR_W'(count_q - skt_pkg::CNT_W'(1));
  assign ptr_inc     = ptr_q + skt_pkg::PTR_W'(1);
  assign ptr_dec     = ptr_q - skt_pkg::PTR_W'(1);
  assign ptr_at_last = (skt_pkg::CNT_W'(ptr_q) + skt_pkg::CNT_W'(1)) == count_q;
  assign in_ready_o  = (state_q == S_IDLE);

  // Walk the table: scan, shift and write back one entry per cycle
  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    key_d      = key_q;
    data_d     = data_q;
    ptr_d      = ptr_q;
    count_d    = count_q;
    res_data_d = res_data_q;
    ram_we     = 1'b0;
    ram_waddr  = ptr_q;
    ram_wdata  = '{key: key_q, data: data_q};
    ram_re     = 1'b0;
    ram_raddr  = ptr_q;
    fin_en     = 1'b0;
    fin_found  = 1'b0;
    fin_data   = '0;
    fin_status = skt_pkg::STATUS_OK;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d  = command_i;
          key_d  = in_key;
          data_d = in_data;
          case (command_i)
            skt_pkg::CMD_INSERT: begin
              if (count_q == skt_pkg::CNT_W'(skt_pkg::DEPTH)) begin
                fin_en     = 1'b1;
                fin_status = skt_pkg::STATUS_FULL;
              end else if (count_q == '0) begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = '{key: in_key, data: in_data};
                count_d   = count_q + skt_pkg::CNT_W'(1);
                fin_en    = 1'b1;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = ptr_last;
                ptr_d     = ptr_last;
                state_d   = S_INS;
              end
            end
            skt_pkg::CMD_LOOKUP, skt_pkg::CMD_REMOVE: begin
              if (count_q == '0) begin
                fin_en     = 1'b1;
                fin_status = skt_pkg::STATUS_NOT_FOUND;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                ptr_d     = '0;
                state_d   = S_SRCH;
              end
            end
            default: begin
              fin_en = 1'b1;
            end
          endcase
        end
      end

      // Move greater keys up one slot until the insert point is found
      S_INS: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_inc;
        if (ram_rdata.key <= key_q) begin
          count_d = count_q + skt_pkg::CNT_W'(1);
          fin_en  = 1'b1;
        end else begin
          ram_wdata = ram_rdata;
          if (ptr_q == '0) begin
            state_d = S_INS_LAST;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = ptr_dec;
            ptr_d     = ptr_dec;
          end
        end
      end

      // New key is the lowest: place it at the bottom
      S_INS_LAST: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        count_d   = count_q + skt_pkg::CNT_W'(1);
        fin_en    = 1'b1;
      end

      // Scan upward for the first matching key
      S_SRCH: begin
        if (ram_rdata.key == key_q) begin
          res_data_d = ram_rdata.data;
          if (cmd_q == skt_pkg::CMD_LOOKUP || ptr_at_last) begin
            if (cmd_q == skt_pkg::CMD_REMOVE) begin
              count_d = count_q - skt_pkg::CNT_W'(1);
            end
            fin_en    = 1'b1;
            fin_found = 1'b1;
            fin_data  = ram_rdata.data;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = ptr_inc;
            ptr_d     = ptr_inc;
            state_d   = S_RM;
          end
        end else if (ptr_at_last) begin
          fin_en     = 1'b1;
          fin_status = skt_pkg::STATUS_NOT_FOUND;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = ptr_inc;
          ptr_d     = ptr_inc;
        end
      end

      // Close the gap: move each higher entry down one slot
      S_RM: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_dec;
        ram_wdata = ram_rdata;
        if (ptr_at_last) begin
          count_d   = count_q - skt_pkg::CNT_W'(1);
          fin_en    = 1'b1;
          fin_found = 1'b1;
          fin_data  = res_data_q;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = ptr_inc;
          ptr_d     = ptr_inc;
        end
      end

      S_HOLD: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Finish: go idle when the result can move out, else hold it
    if (fin_en) begin
      state_d = out_free ? S_IDLE : S_HOLD;
    end
  end

  // Capture the result for a stalled output
  always_comb begin
    res_found_d  = res_found_q;
    res_status_d = res_status_q;
    if (fin_en) begin
      res_found_d  = fin_found;
      res_status_d = fin_status;
    end
  end

  // Load the output register from a fresh or held result
  always_comb begin
    load_out     = (fin_en || state_q == S_HOLD) && out_free;
    out_found_d  = out_found_q;
    out_data_d   = out_data_q;
    out_count_d  = out_count_q;
    out_status_d = out_status_q;
    out_valid_d  = out_ready_i ? 1'b0 : out_valid_q;
    if (load_out) begin
      out_valid_d  = 1'b1;
      out_count_d  = skt_pkg::COUNT_W'(count_d);
      if (fin_en) begin
        out_found_d  = fin_found;
        out_data_d   = skt_pkg::DATA_W'(fin_data);
        out_status_d = fin_status;
      end else begin
        out_found_d  = res_found_q;
        out_data_d   = res_found_q ? skt_pkg::DATA_W'(res_data_q) : '0;
        out_status_d = res_status_q;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    key_q        <= key_d;
    data_q       <= data_d;
    ptr_q        <= ptr_d;
    res_found_q  <= res_found_d;
    res_data_q   <= res_data_d;
    res_status_q <= res_status_d;
    out_found_q  <= out_found_d;
    out_data_q   <= out_data_d;
    out_count_q  <= out_count_d;
    out_status_q <= out_status_d;
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = out_found_q;
  assign found_data_o  = out_data_q;
  assign entry_count_o = out_count_q;
  assign status_o      = out_status_q;

  // Checks
  `SKT_ASSERT(a_count_in_range, count_q <= skt_pkg::CNT_W'(skt_pkg::DEPTH),
              "count above depth")
  `SKT_ASSERT(a_count_step,
              (count_q != $past(count_q)) |->
              ((count_q == $past(count_q) + skt_pkg::CNT_W'(1)) ||
               (count_q == $past(count_q) - skt_pkg::CNT_W'(1))),
              "count moved by more than one")
  `SKT_ASSERT(a_no_rw_clash, (ram_we && ram_re) |-> (ram_waddr != ram_raddr),
              "RAM read and write hit one entry")
  `SKT_ASSERT(a_full_refused,
              (in_valid_i && in_ready_o && command_i == skt_pkg::CMD_INSERT &&
               count_q == skt_pkg::CNT_W'(skt_pkg::DEPTH)) |=> $stable(count_q),
              "insert into full table changed count")
  `SKT_ASSERT(a_hold_needs_busy_out, (state_q == S_HOLD) |-> out_valid_q,
              "result held with empty output register")
  `SKT_ASSERT_ALWAYS(a_reset_clear,
                     (!rst_ni && $past(!rst_ni)) |-> (count_q == '0 && !out_valid_q),
                     "reset did not clear control state")

endmodule

FILE: rtl/skt_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps
module skt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and read, read data registered
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
